### rtl/lvc_pkg.sv
// Package for the viewport line clipper: widths, register indexes, shared types
// and helper functions. No dependencies.
package lvc_pkg;

   localparam int COORD_W    = 24;                      // signed Q16.8
   localparam int DIFF_W     = COORD_W + 1;             // difference of two coordinates
   localparam int PROD_W     = 2 * DIFF_W;              // magnitude product
   localparam int DIV_STEP   = 4;                       // quotient bits per divider stage
   localparam int DIV_W      = ((PROD_W + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
   localparam int DIV_STAGES = DIV_W / DIV_STEP;
   localparam int CROSS_W    = DIV_W + 2;               // signed crossing coordinate
   localparam int DIST_W     = PROD_W + 1;              // squared distance
   localparam int NUM_LANES  = 4;
   localparam int NUM_PAIRS  = 6;
   localparam int REQ_DATA_W = 4 * COORD_W;
   localparam int RSP_BITS   = 4 * COORD_W + 1;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int CSR_IDX_W  = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VIEW_MIN_X = 2'd0,
      CSR_VIEW_MAX_X = 2'd1,
      CSR_VIEW_MIN_Y = 2'd2,
      CSR_VIEW_MAX_Y = 2'd3
   } csr_index_type;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [1:0]                lane_idx_type;
   typedef logic [2:0]                pair_idx_type;

   // lane order of the candidate crossings: left, right, top, bottom
   localparam lane_idx_type PAIR_A [NUM_PAIRS] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
   localparam lane_idx_type PAIR_B [NUM_PAIRS] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

   typedef struct packed {
      coord_type min_x;
      coord_type max_x;
      coord_type min_y;
      coord_type max_y;
   } view_type;

   // travels beside the dividers
   typedef struct packed {
      logic                 valid;
      logic [NUM_LANES-1:0] neg;
      coord_type            sx;
      coord_type            sy;
      logic                 dx_zero;
      logic                 dy_zero;
   } side_type;

   typedef struct packed {
      logic               ok;
      logic [DIST_W-1:0]  len2;
      pair_idx_type       idx;
   } pick_type;

   function automatic logic [DIFF_W-1:0] diff_mag(input logic signed [DIFF_W-1:0] v);
      diff_mag = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
   endfunction

   function automatic logic signed [DIFF_W-1:0] coord_sub(input coord_type a, input coord_type b);
      coord_sub = DIFF_W'($signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b}));
   endfunction

endpackage

### rtl/lvc_div.sv
// Pipelined restoring divider, DIV_STEP quotient bits per stage, one lane.
// Depends on lvc_pkg.
module lvc_div
   import lvc_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [DIV_W-1:0]  num_in,
   input  logic [DIFF_W-1:0] den_in,
   output logic [DIV_W-1:0]  quo_out
);

   logic [DIFF_W-1:0] rem_ff  [DIV_STAGES];
   logic [DIV_W-1:0]  work_ff [DIV_STAGES];
   logic [DIFF_W-1:0] den_ff  [DIV_STAGES];
   logic [DIFF_W-1:0] rem_in  [DIV_STAGES];
   logic [DIV_W-1:0]  work_in [DIV_STAGES];

   genvar k;
   generate
      for (k = 0; k < DIV_STAGES; k++) begin : g_stage
         logic [DIFF_W-1:0] rem_prev;
         logic [DIV_W-1:0]  work_prev;
         logic [DIFF_W-1:0] den_prev;

         if (k == 0) begin : g_first
            assign rem_prev  = '0;
            assign work_prev = num_in;
            assign den_prev  = den_in;
         end else begin : g_next
            assign rem_prev  = rem_ff[k-1];
            assign work_prev = work_ff[k-1];
            assign den_prev  = den_ff[k-1];
         end

         // shift the next dividend bit in, subtract where it fits
         always_comb begin
            logic [DIFF_W:0]  r;
            logic [DIFF_W-1:0] rm;
            logic [DIV_W-1:0]  w;
            rm = rem_prev;
            w  = work_prev;
            for (int s = 0; s < DIV_STEP; s++) begin
               r = {rm, w[DIV_W-1]};
               w = {w[DIV_W-2:0], 1'b0};
               if (r >= {1'b0, den_prev}) begin
                  r    = r - {1'b0, den_prev};
                  w[0] = 1'b1;
               end
               rm = r[DIFF_W-1:0];
            end
            rem_in[k]  = rm;
            work_in[k] = w;
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k]  <= rem_in[k];
               work_ff[k] <= work_in[k];
               den_ff[k]  <= den_prev;
            end
         end
      end
   endgenerate

   assign quo_out = work_ff[DIV_STAGES-1];

endmodule

### rtl/lvc_select.sv
// Back end of the clipper: border tests, pair distances and segment choice,
// ending in the result register. Depends on lvc_pkg.
module lvc_select
   import lvc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  view_type                view,
   input  side_type                side,
   input  logic [DIV_W-1:0]        quo [NUM_LANES],
   output logic                    out_valid,
   output logic                    out_visible,
   output coord_type               out_ax,
   output coord_type               out_ay,
   output coord_type               out_bx,
   output coord_type               out_by
);

   // crossing stage
   logic                 e_valid_ff;
   logic [NUM_LANES-1:0] e_mask_ff, e_mask_in;
   coord_type            e_px_ff [NUM_LANES];
   coord_type            e_py_ff [NUM_LANES];
   coord_type            e_px_in [NUM_LANES];
   coord_type            e_py_in [NUM_LANES];

   // square stage
   logic                 f_valid_ff;
   logic [NUM_LANES-1:0] f_mask_ff;
   coord_type            f_px_ff [NUM_LANES];
   coord_type            f_py_ff [NUM_LANES];
   logic [PROD_W-1:0]    f_sqx_ff [NUM_PAIRS];
   logic [PROD_W-1:0]    f_sqy_ff [NUM_PAIRS];
   logic [PROD_W-1:0]    f_sqx_in [NUM_PAIRS];
   logic [PROD_W-1:0]    f_sqy_in [NUM_PAIRS];

   // result stage
   logic      g_valid_ff;
   logic      g_vis_ff, g_vis_in;
   coord_type g_ax_ff, g_ay_ff, g_bx_ff, g_by_ff;
   coord_type g_ax_in, g_ay_in, g_bx_in, g_by_in;

   function automatic logic signed [CROSS_W-1:0] ext(input coord_type c);
      ext = CROSS_W'(c);
   endfunction

   function automatic pick_type better(input pick_type l, input pick_type r);
      if (!l.ok || (r.ok && r.len2 > l.len2)) better = r;
      else better = l;
   endfunction

   always_comb begin
      logic signed [CROSS_W-1:0] q;
      logic signed [CROSS_W-1:0] c;
      for (int i = 0; i < NUM_LANES; i++) begin
         q = side.neg[i] ? -$signed({2'b00, quo[i]}) : $signed({2'b00, quo[i]});
         if (i < 2) begin
            c = ext(side.sy) + q;
            e_mask_in[i] = (c >= ext(view.min_y)) && (c <= ext(view.max_y));
            e_px_in[i]   = (i == 0) ? view.min_x : view.max_x;
            e_py_in[i]   = c[COORD_W-1:0];
         end else begin
            c = ext(side.sx) + q;
            e_mask_in[i] = (c >= ext(view.min_x)) && (c <= ext(view.max_x));
            e_px_in[i]   = c[COORD_W-1:0];
            e_py_in[i]   = (i == 2) ? view.min_y : view.max_y;
         end
      end
      // axis-aligned lines take the full border span
      if (side.dx_zero) begin
         e_mask_in  = 4'b0011;
         e_px_in[0] = side.sx;
         e_py_in[0] = view.min_y;
         e_px_in[1] = side.sx;
         e_py_in[1] = view.max_y;
      end else if (side.dy_zero) begin
         e_mask_in  = 4'b0011;
         e_px_in[0] = view.min_x;
         e_py_in[0] = side.sy;
         e_px_in[1] = view.max_x;
         e_py_in[1] = side.sy;
      end
   end

   always_comb begin
      logic signed [DIFF_W-1:0] ex;
      logic signed [DIFF_W-1:0] ey;
      for (int p = 0; p < NUM_PAIRS; p++) begin
         ex = coord_sub(e_px_ff[PAIR_A[p]], e_px_ff[PAIR_B[p]]);
         ey = coord_sub(e_py_ff[PAIR_A[p]], e_py_ff[PAIR_B[p]]);
         f_sqx_in[p] = PROD_W'(ex * ex);
         f_sqy_in[p] = PROD_W'(ey * ey);
      end
   end

   // earliest pair wins a tie, as in a sequential scan
   always_comb begin
      pick_type node [NUM_PAIRS];
      pick_type m0, m1, m2, best;
      for (int p = 0; p < NUM_PAIRS; p++) begin
         node[p].ok   = f_mask_ff[PAIR_A[p]] & f_mask_ff[PAIR_B[p]];
         node[p].len2 = DIST_W'(f_sqx_ff[p]) + DIST_W'(f_sqy_ff[p]);
         node[p].idx  = pair_idx_type'(p);
      end
      m0   = better(node[0], node[1]);
      m1   = better(node[2], node[3]);
      m2   = better(node[4], node[5]);
      best = better(better(m0, m1), m2);
      g_vis_in = best.ok;
      g_ax_in  = '0;
      g_ay_in  = '0;
      g_bx_in  = '0;
      g_by_in  = '0;
      if (best.ok) begin
         g_ax_in = f_px_ff[PAIR_A[best.idx]];
         g_ay_in = f_py_ff[PAIR_A[best.idx]];
         g_bx_in = f_px_ff[PAIR_B[best.idx]];
         g_by_in = f_py_ff[PAIR_B[best.idx]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
      end else if (en) begin
         e_valid_ff <= side.valid;
         f_valid_ff <= e_valid_ff;
         g_valid_ff <= f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_mask_ff <= e_mask_in;
         e_px_ff   <= e_px_in;
         e_py_ff   <= e_py_in;
         f_mask_ff <= e_mask_ff;
         f_px_ff   <= e_px_ff;
         f_py_ff   <= e_py_ff;
         f_sqx_ff  <= f_sqx_in;
         f_sqy_ff  <= f_sqy_in;
         g_vis_ff  <= g_vis_in;
         g_ax_ff   <= g_ax_in;
         g_ay_ff   <= g_ay_in;
         g_bx_ff   <= g_bx_in;
         g_by_ff   <= g_by_in;
      end
   end

   assign out_valid   = g_valid_ff;
   assign out_visible = g_vis_ff;
   assign out_ax      = g_ax_ff;
   assign out_ay      = g_ay_ff;
   assign out_bx      = g_bx_ff;
   assign out_by      = g_by_ff;

endmodule

### rtl/infinite_line_viewport_clip_unit.sv
// Top level of the viewport line clipper: viewport registers, front stages,
// four divider lanes and the back end. Depends on lvc_pkg, lvc_div, lvc_select.
//
// Usage: each req_ transaction carries two points of an infinite line; the
// block returns one rsp_ transaction per request, in order, holding the
// visible flag and the two ends of the segment that lies on the viewport
// border. The viewport comes from four registers written through csr_wr_en,
// csr_index and csr_wdata; write them only while no transaction is in flight.
// Pipeline: nineteen register stages (three front, thirteen divider stages at
// four quotient bits each and three back end); the first loads at the request
// edge itself. Throughput: one transaction per cycle when not stalled by
// back-pressure; the pipeline is fully populated and every stage advances
// together.
// Reset: synchronous; empties the pipeline and loads the default viewport
// (0..1023 by 0..767). Back-pressure: while rsp_tvalid is high and rsp_tready
// low, the whole pipeline holds and req_tready drops; nothing is lost or
// repeated, and the waiting result stays in the output register.
module infinite_line_viewport_clip_unit
   import lvc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // start_x, start_y, end_x, end_y
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // visible, seg_a_x, seg_a_y, seg_b_x, seg_b_y, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [COORD_W-1:0]    csr_wdata
);

   view_type  view_ff;
   logic      en;

   // input stage
   logic      a_valid_ff;
   coord_type a_sx_ff, a_sy_ff, a_ex_ff, a_ey_ff;

   // magnitude stage
   logic                 b_valid_ff;
   logic [DIFF_W-1:0]    b_mag_ff [NUM_LANES];
   logic [DIFF_W-1:0]    b_mag_in [NUM_LANES];
   logic [NUM_LANES-1:0] b_sgn_ff, b_sgn_in;
   logic [DIFF_W-1:0]    b_dxm_ff, b_dym_ff, b_dxm_in, b_dym_in;
   logic                 b_dxs_ff, b_dys_ff, b_dxs_in, b_dys_in;
   coord_type            b_sx_ff, b_sy_ff;

   // product stage
   side_type          c_side_ff, c_side_in;
   logic [DIV_W-1:0]  c_num_ff [NUM_LANES];
   logic [DIV_W-1:0]  c_num_in [NUM_LANES];
   logic [DIFF_W-1:0] c_den_ff [NUM_LANES];
   logic [DIFF_W-1:0] c_den_in [NUM_LANES];

   side_type          side_ff [DIV_STAGES];
   logic [DIV_W-1:0]  quo [NUM_LANES];

   logic      out_visible;
   coord_type out_ax, out_ay, out_bx, out_by;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         view_ff.min_x <= '0;
         view_ff.max_x <= COORD_W'(1023 << 8);
         view_ff.min_y <= '0;
         view_ff.max_y <= COORD_W'(767 << 8);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_VIEW_MIN_X: view_ff.min_x <= csr_wdata;
            CSR_VIEW_MAX_X: view_ff.max_x <= csr_wdata;
            CSR_VIEW_MIN_Y: view_ff.min_y <= csr_wdata;
            CSR_VIEW_MAX_Y: view_ff.max_y <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      logic signed [DIFF_W-1:0] dx, dy;
      logic signed [DIFF_W-1:0] n [NUM_LANES];
      dx   = coord_sub(a_ex_ff, a_sx_ff);
      dy   = coord_sub(a_ey_ff, a_sy_ff);
      n[0] = coord_sub(view_ff.min_x, a_sx_ff);
      n[1] = coord_sub(view_ff.max_x, a_sx_ff);
      n[2] = coord_sub(view_ff.min_y, a_sy_ff);
      n[3] = coord_sub(view_ff.max_y, a_sy_ff);
      for (int i = 0; i < NUM_LANES; i++) begin
         b_mag_in[i] = diff_mag(n[i]);
         b_sgn_in[i] = n[i][DIFF_W-1];
      end
      b_dxm_in = diff_mag(dx);
      b_dym_in = diff_mag(dy);
      b_dxs_in = dx[DIFF_W-1];
      b_dys_in = dy[DIFF_W-1];
   end

   // left and right lanes divide by dx, top and bottom by dy
   always_comb begin
      logic [PROD_W-1:0] p;
      for (int i = 0; i < NUM_LANES; i++) begin
         p = (i < 2) ? b_mag_ff[i] * b_dym_ff : b_mag_ff[i] * b_dxm_ff;
         c_num_in[i] = DIV_W'(p);
         c_den_in[i] = (i < 2) ? b_dxm_ff : b_dym_ff;
         c_side_in.neg[i] = b_sgn_ff[i] ^ b_dxs_ff ^ b_dys_ff;
      end
      c_side_in.valid   = b_valid_ff;
      c_side_in.sx      = b_sx_ff;
      c_side_in.sy      = b_sy_ff;
      c_side_in.dx_zero = (b_dxm_ff == '0);
      c_side_in.dy_zero = (b_dym_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_side_ff  <= '0;
         for (int k = 0; k < DIV_STAGES; k++) side_ff[k] <= '0;
      end else if (en) begin
         a_valid_ff <= req_tvalid;
         b_valid_ff <= a_valid_ff;
         c_side_ff  <= c_side_in;
         side_ff[0] <= c_side_ff;
         for (int k = 1; k < DIV_STAGES; k++) side_ff[k] <= side_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_sx_ff  <= req_tdata[COORD_W-1:0];
         a_sy_ff  <= req_tdata[2*COORD_W-1:COORD_W];
         a_ex_ff  <= req_tdata[3*COORD_W-1:2*COORD_W];
         a_ey_ff  <= req_tdata[4*COORD_W-1:3*COORD_W];
         b_mag_ff <= b_mag_in;
         b_sgn_ff <= b_sgn_in;
         b_dxm_ff <= b_dxm_in;
         b_dym_ff <= b_dym_in;
         b_dxs_ff <= b_dxs_in;
         b_dys_ff <= b_dys_in;
         b_sx_ff  <= a_sx_ff;
         b_sy_ff  <= a_sy_ff;
         c_num_ff <= c_num_in;
         c_den_ff <= c_den_in;
      end
   end

   genvar l;
   generate
      for (l = 0; l < NUM_LANES; l++) begin : g_lane
         lvc_div u_div (
            .clock   (clock),
            .en      (en),
            .num_in  (c_num_ff[l]),
            .den_in  (c_den_ff[l]),
            .quo_out (quo[l])
         );
      end
   endgenerate

   lvc_select u_select (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .view        (view_ff),
      .side        (side_ff[DIV_STAGES-1]),
      .quo         (quo),
      .out_valid   (rsp_tvalid),
      .out_visible (out_visible),
      .out_ax      (out_ax),
      .out_ay      (out_ay),
      .out_bx      (out_bx),
      .out_by      (out_by)
   );

   assign rsp_tdata = {(RSP_DATA_W - RSP_BITS)'(0), out_by, out_bx, out_ay, out_ax, out_visible};

endmodule
